FILE: hdl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, constants and fixed-point helpers for the ray against capped
// cylinder unit: signed Q16.16 scalars with saturation.
// ----------------------------------------------------------------------------
package rcc_pkg;

   // fixed-point format
   localparam int FRAC_BITS = 16;
   localparam int EPSILON_Q = 66;

   // shifted product width, square root widths, divider steps
   localparam int PW        = 64 - FRAC_BITS;
   localparam int SQ_IN_W   = 2 * ((32 + FRAC_BITS) / 2);
   localparam int SQ_OUT_W  = SQ_IN_W / 2;
   localparam int DIV_STEPS = 32;

   typedef logic signed [31:0]   q_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef q_type [2:0]          vec_type;
   typedef prod_type [2:0]       pvec_type;

   localparam q_type Q_MAX   = 32'sh7FFF_FFFF;
   localparam q_type Q_MIN   = 32'sh8000_0000;
   localparam q_type NEG_EPS = q_type'(-EPSILON_Q);

   typedef struct packed {
      vec_type org;
      vec_type dir;
   } ray_type;

   localparam int RAY_W = $bits(ray_type);

   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_BASE,
      CAP_TOP
   } cap_sel_type;

   typedef enum logic [2:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_CENTER_Z,
      CSR_AXIS_X,
      CSR_AXIS_Y,
      CSR_AXIS_Z,
      CSR_CYL_RADIUS,
      CSR_CYL_HEIGHT
   } csr_index_type;

   // sideband carried through the square root
   typedef struct packed {
      ray_type ray;
      q_type   a;
      q_type   b;
      logic    ok;
   } tube_side_type;

   // sideband carried through the tube divider
   typedef struct packed {
      ray_type ray;
      logic    ok;
   } root_side_type;

   // sideband carried through the cap divider
   typedef struct packed {
      ray_type     ray;
      vec_type     cp;
      logic        go;
      cap_sel_type sel;
      q_type       t_tube;
   } disk_side_type;

   // clamp a wide signed value to the 32-bit range
   function automatic q_type sat_q(input logic signed [65:0] v);
      if (!v[65] && (v[64:31] != '0)) return Q_MAX;
      if (v[65] && (v[64:31] != '1)) return Q_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [65:0] ext_q(input q_type x);
      return {{34{x[31]}}, x};
   endfunction

   function automatic logic signed [65:0] ext_p(input prod_type p);
      return {{(66 - PW){p[PW-1]}}, p};
   endfunction

   function automatic q_type add_q(input q_type x, input q_type y);
      return sat_q(ext_q(x) + ext_q(y));
   endfunction

   function automatic q_type sub_q(input q_type x, input q_type y);
      return sat_q(ext_q(x) - ext_q(y));
   endfunction

   // full product shifted down by the fraction bits, rounding toward minus infinity
   function automatic prod_type prod_sh(input q_type x, input q_type y);
      logic signed [63:0] p;
      p = x * y;
      return p[63:FRAC_BITS];
   endfunction

   function automatic q_type mul_q(input q_type x, input q_type y);
      return sat_q(ext_p(prod_sh(x, y)));
   endfunction

   // exact sum of three shifted products, then clamp
   function automatic q_type dot_q(input prod_type p0, input prod_type p1,
                                   input prod_type p2);
      return sat_q(ext_p(p0) + ext_p(p1) + ext_p(p2));
   endfunction

endpackage

FILE: hdl/ray_capped_cylinder_intersection_unit.sv
// Throughput: one ray per cycle; the whole pipeline holds while rsp_ready is low
// and the output register is full. Most of the pipeline depth lies in the two
// 34-stage dividers and the 25-stage square root, whose step stages each retire
// one result bit. Reset clears all valid bits and sets the cylinder registers
// to their defaults; derived cylinder terms are registered and follow a
// register write in the next cycle.
// ----------------------------------------------------------------------------
// ray_capped_cylinder_intersection_unit
// Ray against one capped cylinder in signed Q16.16: tube quadratic, near root,
// then end-disk test when the hit lies past either end. Depth 0 is a miss.
// ----------------------------------------------------------------------------
module ray_capped_cylinder_intersection_unit (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rcc_pkg::q_type req_origin_x,
   input  rcc_pkg::q_type req_origin_y,
   input  rcc_pkg::q_type req_origin_z,
   input  rcc_pkg::q_type req_dir_x,
   input  rcc_pkg::q_type req_dir_y,
   input  rcc_pkg::q_type req_dir_z,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rcc_pkg::q_type rsp_hit_depth,
   input  logic           csr_write_en,
   input  logic [2:0]     csr_index,
   input  logic [31:0]    csr_wdata
);
   import rcc_pkg::*;

   logic adv;

   // cylinder registers
   vec_type            center_ff;
   logic signed [17:0] axis_ff [3];
   logic [30:0]        radius_ff;
   logic [30:0]        height_ff;
   vec_type            ax;
   q_type              rr_ff, rr_in;
   vec_type            cp_top_ff, cp_top_in;
   logic [31:0]        lim;
   logic [63:0]        lim2_ff, lim2_in;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff, v15_ff, v16_ff, v17_ff;
   logic v18_ff, v19_ff, v20_ff, v21_ff;

   // tube front end
   ray_type  ray_in, ray1_ff, ray2_ff, ray3_ff, ray4_ff, ray5_ff, ray6_ff, ray7_ff;
   vec_type  po_in, po1_ff;
   pvec_type pdn_in, ppn_in, pdd_in, pdp_in, ppp_in;
   pvec_type pdn2_ff, ppn2_ff, pdd2_ff, pdp2_ff, ppp2_ff;
   q_type    dn3_ff, pn3_ff, dd3_ff, dp3_ff, pp3_ff;
   q_type    dd4_ff, dp4_ff, pp4_ff, mnn4_ff, mnp4_ff, mpp4_ff;
   q_type    a5_ff, b5_ff, c5_ff;
   q_type    a6_ff, b6_ff, bb6_ff, ac6_ff;
   q_type    a7_ff, b7_ff, disc7_ff;

   // square root and tube divide
   tube_side_type       sq_side_in, sq_side;
   logic                sq_vld;
   logic [SQ_OUT_W-1:0] sq_root;
   ray_type             ray8_ff;
   q_type               a8_ff, num8_ff;
   logic                ok8_ff;
   root_side_type       d1_side_in, d1_side;
   logic                d1_vld;
   q_type               d1_quot;

   // hit point and axial offset
   q_type       t9_in, t9_ff, t10_ff, t11_ff, t12_ff, t13_ff, t14_ff, t15_ff;
   q_type       t16_ff, t17_ff;
   ray_type     ray9_ff, ray10_ff, ray11_ff, ray12_ff, ray13_ff, ray14_ff;
   ray_type     ray15_ff, ray16_ff, ray17_ff;
   vec_type     md9_in, md9_ff, th10_in, th10_ff;
   pvec_type    pth11_in, pth11_ff;
   q_type       off12_ff;
   cap_sel_type sel13_in, sel13_ff, sel14_ff, sel15_ff, sel16_ff, sel17_ff;
   vec_type     nrm13_in, nrm13_ff, nrm14_ff, nrm15_ff;
   vec_type     cp13_in, cp13_ff, cp14_ff, cp15_ff, cp16_ff, cp17_ff;

   // end disk plane
   pvec_type      pde14_in, pde14_ff, pdf16_in, pdf16_ff;
   vec_type       diff14_in, diff14_ff, diff15_ff;
   q_type         denom15_ff, denom16_ff, denom17_ff, dnum17_ff;
   logic          go16_ff, go17_ff;
   disk_side_type d2_side_in, d2_side;
   logic          d2_vld;
   q_type         d2_quot;

   // disk radius check
   q_type       t2_18_in, t2_18_ff, t2_19_ff, t2_20_ff;
   q_type       t18_ff, t19_ff, t20_ff;
   cap_sel_type sel18_ff, sel19_ff, sel20_ff;
   vec_type     org18_ff, cp18_ff, md18_in, md18_ff;
   logic [31:0] dm19_in [3];
   logic [31:0] dm19_ff [3];
   logic [63:0] sq20_ff [3];
   logic [63:0] dist2;
   q_type       depth_in, depth_ff;

   // pipeline moves when the output register is free or being taken
   assign adv       = !v21_ff || rsp_ready;
   assign req_ready = adv;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff  <= '0;
         axis_ff[0] <= '0;
         axis_ff[1] <= 18'sd65536;
         axis_ff[2] <= '0;
         radius_ff  <= 31'd65536;
         height_ff  <= 31'd65536;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CENTER_X:   center_ff[0] <= csr_wdata;
            CSR_CENTER_Y:   center_ff[1] <= csr_wdata;
            CSR_CENTER_Z:   center_ff[2] <= csr_wdata;
            CSR_AXIS_X:     axis_ff[0]   <= csr_wdata[17:0];
            CSR_AXIS_Y:     axis_ff[1]   <= csr_wdata[17:0];
            CSR_AXIS_Z:     axis_ff[2]   <= csr_wdata[17:0];
            CSR_CYL_RADIUS: radius_ff    <= csr_wdata[30:0];
            CSR_CYL_HEIGHT: height_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // derived cylinder terms: squared radius, top cap centre, disk limit
   always_comb begin
      for (int i = 0; i < 3; i++) ax[i] = {{14{axis_ff[i][17]}}, axis_ff[i]};
      rr_in = mul_q({1'b0, radius_ff}, {1'b0, radius_ff});
      for (int i = 0; i < 3; i++) begin
         cp_top_in[i] = add_q(center_ff[i], mul_q(ax[i], {1'b0, height_ff}));
      end
      lim     = {1'b0, radius_ff} + 32'(EPSILON_Q);
      lim2_in = {32'b0, lim} * {32'b0, lim};
   end

   always_ff @(posedge clock) begin
      rr_ff     <= rr_in;
      cp_top_ff <= cp_top_in;
      lim2_ff   <= lim2_in;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff} <= '0;
         {v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff, v15_ff} <= '0;
         {v16_ff, v17_ff, v18_ff, v19_ff, v20_ff, v21_ff} <= '0;
      end else if (adv) begin
         v1_ff  <= req_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= sq_vld;
         v9_ff  <= d1_vld;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
         v14_ff <= v13_ff;
         v15_ff <= v14_ff;
         v16_ff <= v15_ff;
         v17_ff <= v16_ff;
         v18_ff <= d2_vld;
         v19_ff <= v18_ff;
         v20_ff <= v19_ff;
         v21_ff <= v20_ff;
      end
   end

   // tube front end: offsets, dot products, quadratic coefficients
   always_comb begin
      ray_in.org = {req_origin_z, req_origin_y, req_origin_x};
      ray_in.dir = {req_dir_z, req_dir_y, req_dir_x};
      for (int i = 0; i < 3; i++) begin
         po_in[i]  = sub_q(ray_in.org[i], center_ff[i]);
         pdn_in[i] = prod_sh(ray1_ff.dir[i], ax[i]);
         ppn_in[i] = prod_sh(po1_ff[i], ax[i]);
         pdd_in[i] = prod_sh(ray1_ff.dir[i], ray1_ff.dir[i]);
         pdp_in[i] = prod_sh(ray1_ff.dir[i], po1_ff[i]);
         ppp_in[i] = prod_sh(po1_ff[i], po1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ray1_ff  <= ray_in;
         po1_ff   <= po_in;
         ray2_ff  <= ray1_ff;
         pdn2_ff  <= pdn_in;
         ppn2_ff  <= ppn_in;
         pdd2_ff  <= pdd_in;
         pdp2_ff  <= pdp_in;
         ppp2_ff  <= ppp_in;
         ray3_ff  <= ray2_ff;
         dn3_ff   <= dot_q(pdn2_ff[0], pdn2_ff[1], pdn2_ff[2]);
         pn3_ff   <= dot_q(ppn2_ff[0], ppn2_ff[1], ppn2_ff[2]);
         dd3_ff   <= dot_q(pdd2_ff[0], pdd2_ff[1], pdd2_ff[2]);
         dp3_ff   <= dot_q(pdp2_ff[0], pdp2_ff[1], pdp2_ff[2]);
         pp3_ff   <= dot_q(ppp2_ff[0], ppp2_ff[1], ppp2_ff[2]);
         ray4_ff  <= ray3_ff;
         dd4_ff   <= dd3_ff;
         dp4_ff   <= dp3_ff;
         pp4_ff   <= pp3_ff;
         mnn4_ff  <= mul_q(dn3_ff, dn3_ff);
         mnp4_ff  <= mul_q(dn3_ff, pn3_ff);
         mpp4_ff  <= mul_q(pn3_ff, pn3_ff);
         ray5_ff  <= ray4_ff;
         a5_ff    <= sub_q(dd4_ff, mnn4_ff);
         b5_ff    <= sub_q(dp4_ff, mnp4_ff);
         c5_ff    <= sub_q(sub_q(pp4_ff, mpp4_ff), rr_ff);
         ray6_ff  <= ray5_ff;
         a6_ff    <= a5_ff;
         b6_ff    <= b5_ff;
         bb6_ff   <= mul_q(b5_ff, b5_ff);
         ac6_ff   <= mul_q(a5_ff, c5_ff);
         ray7_ff  <= ray6_ff;
         a7_ff    <= a6_ff;
         b7_ff    <= b6_ff;
         disc7_ff <= sub_q(bb6_ff, ac6_ff);
      end
   end

   // discriminant root
   always_comb begin
      sq_side_in.ray = ray7_ff;
      sq_side_in.a   = a7_ff;
      sq_side_in.b   = b7_ff;
      sq_side_in.ok  = !disc7_ff[31] && (a7_ff != 0);
   end

   rcc_sqrt #(
      .SIDE_W ($bits(tube_side_type))
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (v7_ff),
      .in_value (disc7_ff),
      .in_side  (sq_side_in),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // near root numerator
   always_ff @(posedge clock) begin
      if (adv) begin
         ray8_ff <= sq_side.ray;
         a8_ff   <= sq_side.a;
         ok8_ff  <= sq_side.ok;
         num8_ff <= sat_q(-ext_q(sq_side.b) - {{(66 - SQ_OUT_W){1'b0}}, sq_root});
      end
   end

   always_comb begin
      d1_side_in.ray = ray8_ff;
      d1_side_in.ok  = ok8_ff;
   end

   rcc_div #(
      .SIDE_W ($bits(root_side_type))
   ) u_div_tube (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (v8_ff),
      .in_num   (num8_ff),
      .in_den   (a8_ff),
      .in_side  (d1_side_in),
      .out_vld  (d1_vld),
      .out_quot (d1_quot),
      .out_side (d1_side)
   );

   // tube hit point, axial offset, cap choice, disk plane terms
   always_comb begin
      t9_in = d1_side.ok ? d1_quot : '0;
      for (int i = 0; i < 3; i++) begin
         md9_in[i]   = mul_q(d1_side.ray.dir[i], t9_in);
         th10_in[i]  = sub_q(add_q(ray9_ff.org[i], md9_ff[i]), center_ff[i]);
         pth11_in[i] = prod_sh(th10_ff[i], ax[i]);
      end
      if (off12_ff < 0) begin
         sel13_in = CAP_BASE;
      end else if (off12_ff > $signed({1'b0, height_ff})) begin
         sel13_in = CAP_TOP;
      end else begin
         sel13_in = CAP_NONE;
      end
      for (int i = 0; i < 3; i++) begin
         nrm13_in[i]  = (sel13_in == CAP_BASE) ? sub_q('0, ax[i]) : ax[i];
         cp13_in[i]   = (sel13_in == CAP_BASE) ? center_ff[i] : cp_top_ff[i];
         pde14_in[i]  = prod_sh(nrm13_ff[i], ray13_ff.dir[i]);
         diff14_in[i] = sub_q(cp13_ff[i], ray13_ff.org[i]);
         pdf16_in[i]  = prod_sh(diff15_ff[i], nrm15_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ray9_ff    <= d1_side.ray;
         t9_ff      <= t9_in;
         md9_ff     <= md9_in;
         ray10_ff   <= ray9_ff;
         t10_ff     <= t9_ff;
         th10_ff    <= th10_in;
         ray11_ff   <= ray10_ff;
         t11_ff     <= t10_ff;
         pth11_ff   <= pth11_in;
         ray12_ff   <= ray11_ff;
         t12_ff     <= t11_ff;
         off12_ff   <= dot_q(pth11_ff[0], pth11_ff[1], pth11_ff[2]);
         ray13_ff   <= ray12_ff;
         t13_ff     <= t12_ff;
         sel13_ff   <= sel13_in;
         nrm13_ff   <= nrm13_in;
         cp13_ff    <= cp13_in;
         ray14_ff   <= ray13_ff;
         t14_ff     <= t13_ff;
         sel14_ff   <= sel13_ff;
         nrm14_ff   <= nrm13_ff;
         cp14_ff    <= cp13_ff;
         pde14_ff   <= pde14_in;
         diff14_ff  <= diff14_in;
         ray15_ff   <= ray14_ff;
         t15_ff     <= t14_ff;
         sel15_ff   <= sel14_ff;
         nrm15_ff   <= nrm14_ff;
         cp15_ff    <= cp14_ff;
         diff15_ff  <= diff14_ff;
         denom15_ff <= dot_q(pde14_ff[0], pde14_ff[1], pde14_ff[2]);
         ray16_ff   <= ray15_ff;
         t16_ff     <= t15_ff;
         sel16_ff   <= sel15_ff;
         cp16_ff    <= cp15_ff;
         denom16_ff <= denom15_ff;
         go16_ff    <= denom15_ff < NEG_EPS;
         pdf16_ff   <= pdf16_in;
         ray17_ff   <= ray16_ff;
         t17_ff     <= t16_ff;
         sel17_ff   <= sel16_ff;
         cp17_ff    <= cp16_ff;
         denom17_ff <= denom16_ff;
         go17_ff    <= go16_ff;
         dnum17_ff  <= dot_q(pdf16_ff[0], pdf16_ff[1], pdf16_ff[2]);
      end
   end

   always_comb begin
      d2_side_in.ray    = ray17_ff;
      d2_side_in.cp     = cp17_ff;
      d2_side_in.go     = go17_ff;
      d2_side_in.sel    = sel17_ff;
      d2_side_in.t_tube = t17_ff;
   end

   rcc_div #(
      .SIDE_W ($bits(disk_side_type))
   ) u_div_disk (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (v17_ff),
      .in_num   (dnum17_ff),
      .in_den   (denom17_ff),
      .in_side  (d2_side_in),
      .out_vld  (d2_vld),
      .out_quot (d2_quot),
      .out_side (d2_side)
   );

   // disk hit point, distance from cap centre, final pick
   always_comb begin
      t2_18_in = d2_side.go ? d2_quot : '0;
      for (int i = 0; i < 3; i++) begin
         md18_in[i] = mul_q(d2_side.ray.dir[i], t2_18_in);
      end
      for (int i = 0; i < 3; i++) begin
         dm19_in[i] = 32'(sub_q(add_q(org18_ff[i], md18_ff[i]), cp18_ff[i]));
         if (dm19_in[i][31]) dm19_in[i] = 32'd0 - dm19_in[i];
      end
      dist2 = sq20_ff[0] + sq20_ff[1] + sq20_ff[2];
      if (sel20_ff == CAP_NONE) begin
         depth_in = t20_ff;
      end else if (dist2 > lim2_ff) begin
         depth_in = '0;
      end else begin
         depth_in = t2_20_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         org18_ff <= d2_side.ray.org;
         cp18_ff  <= d2_side.cp;
         sel18_ff <= d2_side.sel;
         t18_ff   <= d2_side.t_tube;
         t2_18_ff <= t2_18_in;
         md18_ff  <= md18_in;
         sel19_ff <= sel18_ff;
         t19_ff   <= t18_ff;
         t2_19_ff <= t2_18_ff;
         dm19_ff  <= dm19_in;
         sel20_ff <= sel19_ff;
         t20_ff   <= t19_ff;
         t2_20_ff <= t2_19_ff;
         for (int i = 0; i < 3; i++) sq20_ff[i] <= {32'b0, dm19_ff[i]} * {32'b0, dm19_ff[i]};
         depth_ff <= depth_in;
      end
   end

   assign rsp_valid     = v21_ff;
   assign rsp_hit_depth = depth_ff;

endmodule

FILE: hdl/rcc_sqrt.sv
// ----------------------------------------------------------------------------
// rcc_sqrt
// Pipelined integer square root: floor(sqrt(v << FRAC_BITS)), one result bit
// per stage, zero for a value at or below zero. Sideband rides along.
// ----------------------------------------------------------------------------
module rcc_sqrt #(
   parameter int SIDE_W = rcc_pkg::RAY_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_vld,
   input  rcc_pkg::q_type               in_value,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_vld,
   output logic [rcc_pkg::SQ_OUT_W-1:0] out_root,
   output logic [SIDE_W-1:0]            out_side
);
   import rcc_pkg::*;

   localparam int N  = SQ_OUT_W;
   localparam int RW = SQ_OUT_W + 3;

   logic                vld_ff  [0:N];
   logic [SQ_IN_W-1:0]  rad_ff  [0:N];
   logic [RW-1:0]       rem_ff  [0:N];
   logic [N-1:0]        root_ff [0:N];
   logic [SIDE_W-1:0]   side_ff [0:N];
   logic [SQ_IN_W-1:0]  rad_in;

   // scale the operand, clamp non-positive values to zero
   always_comb begin
      if (in_value <= 0) begin
         rad_in = '0;
      end else begin
         rad_in = SQ_IN_W'(in_value[30:0]) << FRAC_BITS;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k <= N; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // entry stage
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff[0]  <= rad_in;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // one result bit per stage
   for (genvar k = 0; k < N; k++) begin : g_step
      logic [RW-1:0] part;
      logic [RW-1:0] test;
      always_comb begin
         part = {rem_ff[k][RW-3:0], rad_ff[k][SQ_IN_W-1 -: 2]};
         test = {1'b0, root_ff[k], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k+1]  <= rad_ff[k] << 2;
            side_ff[k+1] <= side_ff[k];
            if (part >= test) begin
               rem_ff[k+1]  <= part - test;
               root_ff[k+1] <= {root_ff[k][N-2:0], 1'b1};
            end else begin
               rem_ff[k+1]  <= part;
               root_ff[k+1] <= {root_ff[k][N-2:0], 1'b0};
            end
         end
      end
   end

   assign out_vld  = vld_ff[N];
   assign out_root = root_ff[N];
   assign out_side = side_ff[N];

endmodule

FILE: hdl/rcc_div.sv
// ----------------------------------------------------------------------------
// rcc_div
// Pipelined fixed-point divide: (num << FRAC_BITS) / den truncated toward
// zero and clamped, zero for a zero divisor. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rcc_div #(
   parameter int SIDE_W = rcc_pkg::RAY_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  rcc_pkg::q_type    in_num,
   input  rcc_pkg::q_type    in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output rcc_pkg::q_type    out_quot,
   output logic [SIDE_W-1:0] out_side
);
   import rcc_pkg::*;

   localparam int N = DIV_STEPS;

   logic              vld_ff  [0:N+1];
   logic [31:0]       rem_ff  [0:N];
   logic [31:0]       dl_ff   [0:N];
   logic [31:0]       quo_ff  [0:N];
   logic [31:0]       den_ff  [0:N];
   logic              neg_ff  [0:N];
   logic              zero_ff [0:N];
   logic              ovf_ff  [0:N];
   logic [SIDE_W-1:0] side_ff [0:N];
   logic [SIDE_W-1:0] side_out_ff;
   q_type             quot_ff;
   q_type             quot_in;
   logic [31:0]       num_mag;
   logic [31:0]       den_mag;
   logic              ovf_in;

   // magnitudes and early overflow check on the upper quotient bits
   always_comb begin
      num_mag = in_num[31] ? 32'(-in_num) : 32'(in_num);
      den_mag = in_den[31] ? 32'(-in_den) : 32'(in_den);
      ovf_in  = {32'b0, num_mag} >= ({32'b0, den_mag} << (32 - FRAC_BITS));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N + 1; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k <= N + 1; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // entry stage
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= num_mag >> (32 - FRAC_BITS);
         dl_ff[0]   <= num_mag << FRAC_BITS;
         quo_ff[0]  <= '0;
         den_ff[0]  <= den_mag;
         neg_ff[0]  <= in_num[31] ^ in_den[31];
         zero_ff[0] <= (in_den == 0);
         ovf_ff[0]  <= ovf_in;
         side_ff[0] <= in_side;
      end
   end

   // restoring steps, one quotient bit each
   for (genvar k = 0; k < N; k++) begin : g_step
      logic [32:0] part;
      always_comb begin
         part = {rem_ff[k], dl_ff[k][31]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dl_ff[k+1]   <= dl_ff[k] << 1;
            den_ff[k+1]  <= den_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            side_ff[k+1] <= side_ff[k];
            if (part >= {1'b0, den_ff[k]}) begin
               rem_ff[k+1] <= 32'(part - {1'b0, den_ff[k]});
               quo_ff[k+1] <= {quo_ff[k][30:0], 1'b1};
            end else begin
               rem_ff[k+1] <= part[31:0];
               quo_ff[k+1] <= {quo_ff[k][30:0], 1'b0};
            end
         end
      end
   end

   // sign and clamp
   always_comb begin
      if (zero_ff[N]) begin
         quot_in = '0;
      end else if (ovf_ff[N]) begin
         quot_in = neg_ff[N] ? Q_MIN : Q_MAX;
      end else if (neg_ff[N]) begin
         quot_in = (quo_ff[N] > 32'h8000_0000) ? Q_MIN : q_type'(32'd0 - quo_ff[N]);
      end else begin
         quot_in = quo_ff[N][31] ? Q_MAX : q_type'(quo_ff[N]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quot_ff     <= quot_in;
         side_out_ff <= side_ff[N];
      end
   end

   assign out_vld  = vld_ff[N+1];
   assign out_quot = quot_ff;
   assign out_side = side_out_ff;

endmodule

FILE: tb/ray_capped_cylinder_intersection_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_capped_cylinder_intersection_unit_tb
// Streams rays through the capped cylinder unit under several cylinder
// settings, predicts each hit depth in signed Q16.16 or takes it from a
// directed row, checks every response beat in order, with random idling on
// both sides and a long response hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module ray_capped_cylinder_intersection_unit_tb;
   import rcc_pkg::*;

   localparam int  N_RANDOM   = 400;
   localparam int  DRAIN      = 150;
   localparam int  LIMIT      = 600000;
   localparam longint QMAX    = 64'sd2147483647;
   localparam longint QMIN    = -64'sd2147483648;
   localparam longint ONE     = 64'sd65536;

   typedef struct {
      q_type ox, oy, oz, dx, dy, dz;
      bit    known;
      q_type depth;
   } ray_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   q_type         req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   q_type         req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   q_type         rsp_hit_depth;
   logic          csr_write_en = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_wdata = '0;

   // cylinder as the predictor sees it
   longint cyl_cen[3], cyl_ax[3], cyl_rad, cyl_hgt;

   q_type  depth_q[$];
   int     n_rays = 0;
   int     n_bad = 0;
   int     cycles = 0;
   int     hold_left = 0;
   bit     hold_done = 1'b0;
   bit     quiet;

   ray_capped_cylinder_intersection_unit i_dut (.*);

   always #6 clock = ~clock;

   assign quiet = (n_rays >= 700) && (n_rays < 1000);

   // ---------------- fixed-point predictor ----------------
   function automatic longint clamp(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic longint fmul(longint a, longint b);
      return clamp((a * b) >>> FRAC_BITS);
   endfunction

   function automatic longint fdot(longint a0, longint a1, longint a2,
                                   longint b0, longint b1, longint b2);
      return clamp(((a0 * b0) >>> FRAC_BITS) + ((a1 * b1) >>> FRAC_BITS)
                   + ((a2 * b2) >>> FRAC_BITS));
   endfunction

   function automatic longint fdiv(longint num, longint den);
      if (den == 0) return 0;
      return clamp((num * ONE) / den);
   endfunction

   function automatic longint fsqrt(longint v);
      longint unsigned x, r, b;
      r = 0;
      b = 64'd1 << 62;
      if (v <= 0) return 0;
      x = longint'(v) << FRAC_BITS;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // depth of the plane through cp with normal n, zero if outside the disk
   function automatic longint cap_depth(longint o[3], longint d[3], longint cp[3],
                                        longint n[3]);
      longint denom, t, df[3], hp, dd;
      longint unsigned dist2, m, lim;
      t = 0;
      dist2 = 0;
      denom = fdot(n[0], n[1], n[2], d[0], d[1], d[2]);
      if (denom < -longint'(EPSILON_Q)) begin
         for (int i = 0; i < 3; i++) df[i] = clamp(cp[i] - o[i]);
         t = fdiv(fdot(df[0], df[1], df[2], n[0], n[1], n[2]), denom);
      end
      for (int i = 0; i < 3; i++) begin
         hp = clamp(o[i] + fmul(d[i], t));
         dd = clamp(hp - cp[i]);
         m = (dd < 0) ? longint'(-dd) : longint'(dd);
         dist2 = dist2 + m * m;
      end
      lim = longint'(cyl_rad) + EPSILON_Q;
      if (dist2 > lim * lim) return 0;
      return t;
   endfunction

   function automatic q_type hit_depth(q_type ox, q_type oy, q_type oz,
                                       q_type dx, q_type dy, q_type dz);
      longint o[3], d[3], po[3], th[3], n[3], cp[3];
      longint dn, pn, a, b, c, disc, t, off;
      o = '{ox, oy, oz};
      d = '{dx, dy, dz};
      for (int i = 0; i < 3; i++) po[i] = clamp(o[i] - cyl_cen[i]);
      // infinite tube, near root
      dn = fdot(d[0], d[1], d[2], cyl_ax[0], cyl_ax[1], cyl_ax[2]);
      pn = fdot(po[0], po[1], po[2], cyl_ax[0], cyl_ax[1], cyl_ax[2]);
      a = clamp(fdot(d[0], d[1], d[2], d[0], d[1], d[2]) - fmul(dn, dn));
      b = clamp(fdot(d[0], d[1], d[2], po[0], po[1], po[2]) - fmul(dn, pn));
      c = clamp(clamp(fdot(po[0], po[1], po[2], po[0], po[1], po[2]) - fmul(pn, pn))
                - fmul(cyl_rad, cyl_rad));
      disc = clamp(fmul(b, b) - fmul(a, c));
      t = (disc < 0 || a == 0) ? 0 : fdiv(clamp(-b - fsqrt(disc)), a);
      // axial offset of the tube point
      for (int i = 0; i < 3; i++) th[i] = clamp(clamp(o[i] + fmul(d[i], t)) - cyl_cen[i]);
      off = fdot(th[0], th[1], th[2], cyl_ax[0], cyl_ax[1], cyl_ax[2]);
      if (off < 0) begin
         for (int i = 0; i < 3; i++) n[i] = -cyl_ax[i];
         t = cap_depth(o, d, cyl_cen, n);
      end else if (off > cyl_hgt) begin
         for (int i = 0; i < 3; i++) cp[i] = clamp(cyl_cen[i] + fmul(cyl_ax[i], cyl_hgt));
         t = cap_depth(o, d, cp, cyl_ax);
      end
      return q_type'(t);
   endfunction

   // ---------------- register writes ----------------
   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CENTER_X:   cyl_cen[0] = longint'(signed'(val));
         CSR_CENTER_Y:   cyl_cen[1] = longint'(signed'(val));
         CSR_CENTER_Z:   cyl_cen[2] = longint'(signed'(val));
         CSR_AXIS_X:     cyl_ax[0] = longint'(signed'(val[17:0]));
         CSR_AXIS_Y:     cyl_ax[1] = longint'(signed'(val[17:0]));
         CSR_AXIS_Z:     cyl_ax[2] = longint'(signed'(val[17:0]));
         CSR_CYL_RADIUS: cyl_rad = longint'({1'b0, val[30:0]});
         CSR_CYL_HEIGHT: cyl_hgt = longint'({1'b0, val[30:0]});
         default: ;
      endcase
   endtask

   task automatic set_cylinder(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                               logic [31:0] rad, logic [31:0] hgt);
      // stop offering rays, then wait until the pipeline is empty
      req_valid <= 1'b0;
      while (depth_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      csr_write(CSR_CENTER_Z, cz);
      csr_write(CSR_AXIS_X, ax);
      csr_write(CSR_AXIS_Y, ay);
      csr_write(CSR_AXIS_Z, az);
      csr_write(CSR_CYL_RADIUS, rad);
      csr_write(CSR_CYL_HEIGHT, hgt);
      csr_write_en <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // ---------------- request side ----------------
   task automatic send_ray(ray_row_type r, bit use_typed);
      int gap;
      if (!quiet && $urandom_range(99) < 25) begin
         gap = $urandom_range(1, 2);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_origin_x <= r.ox; req_origin_y <= r.oy; req_origin_z <= r.oz;
      req_dir_x <= r.dx; req_dir_y <= r.dy; req_dir_z <= r.dz;
      do @(posedge clock); while (!req_ready);
      depth_q.push_back(use_typed ? r.depth
                        : hit_depth(r.ox, r.oy, r.oz, r.dx, r.dy, r.dz));
      n_rays++;
   endtask

   function automatic q_type near_center(int k, int span);
      return q_type'(clamp(cyl_cen[k] + $signed($urandom_range(2 * span)) - span));
   endfunction

   task automatic send_random();
      ray_row_type r;
      int mode, k;
      mode = $urandom_range(99);
      r.known = 1'b0;
      r.depth = '0;
      if (mode < 70) begin
         // ray starting near the cylinder, modest direction
         r.ox = near_center(0, 5 * 65536);
         r.oy = near_center(1, 5 * 65536);
         r.oz = near_center(2, 5 * 65536);
         r.dx = $signed($urandom_range(4 * 65536)) - 2 * 65536;
         r.dy = $signed($urandom_range(4 * 65536)) - 2 * 65536;
         r.dz = $signed($urandom_range(4 * 65536)) - 2 * 65536;
      end else if (mode < 85) begin
         r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
         r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
      end else begin
         // along or against the axis, from near the base centre
         k = $urandom_range(1) ? 1 : -1;
         r.ox = near_center(0, 3 * 65536);
         r.oy = near_center(1, 3 * 65536);
         r.oz = near_center(2, 3 * 65536);
         r.dx = q_type'(k * cyl_ax[0]);
         r.dy = q_type'(k * cyl_ax[1]);
         r.dz = q_type'(k * cyl_ax[2]);
      end
      send_ray(r, 1'b0);
   endtask

   // ---------------- response side ----------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         if (!reset && rsp_valid && rsp_ready) begin
            if (depth_q.size() == 0) begin
               n_bad = n_bad + 1;
               if (n_bad <= 10) $display("unexpected beat, hit_depth %0d", rsp_hit_depth);
            end else begin
               q_type want;
               want = depth_q.pop_front();
               if (rsp_hit_depth !== want) begin
                  n_bad = n_bad + 1;
                  if (n_bad <= 10)
                     $display("hit_depth mismatch: expected %0d, got %0d",
                              want, rsp_hit_depth);
               end
            end
         end
         // long hold-off to back the pipeline up
         if (!hold_done && n_rays >= 200) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 25);
         end
      end
   end

   // ---------------- main sequence ----------------
   ray_row_type dir_rows[13];

   initial begin
      cyl_cen = '{0, 0, 0};
      cyl_ax = '{0, ONE, 0};
      cyl_rad = ONE;
      cyl_hgt = ONE;
      dir_rows = '{
         // side hit at one unit
         '{-32'sd131072, 32'sd32768, 0, 32'sd65536, 0, 0, 1'b1, 32'sd65536},
         '{0, 0, 0, 0, 0, 0, 1'b1, 0},
         // down the axis onto the top cap
         '{0, 32'sd196608, 0, 0, -32'sd65536, 0, 1'b1, 32'sd131072},
         // facing away from the top cap
         '{0, 32'sd196608, 0, 0, 32'sd65536, 0, 1'b1, 0},
         // up the axis onto the base cap
         '{0, -32'sd131072, 0, 0, 32'sd65536, 0, 1'b1, 32'sd131072},
         // plane hit outside the cap radius
         '{32'sd196608, 32'sd196608, 0, 0, -32'sd65536, 0, 1'b1, 0},
         '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 0},
         '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0},
         '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0, 0},
         '{-32'sd131072, 32'sd327680, 0, 32'sd65536, 0, 0, 1'b0, 0},
         '{-32'sd131072, 32'sd32768, 0, 32'sd1, 0, 0, 1'b0, 0},
         '{-32'sd131072, -32'sd65536, -32'sd131072, 32'sd65536, 32'sd65536,
           32'sd65536, 1'b0, 0},
         '{32'sd327680, 32'sd327680, 32'sd327680, -32'sd65536, -32'sd65536,
           -32'sd65536, 1'b0, 0}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_ray(dir_rows[i], dir_rows[i].known);
      repeat (N_RANDOM) send_random();

      // axis along z, offset centre
      set_cylinder(32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000, 32'h0, 32'h0,
                   32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      repeat (N_RANDOM) send_random();

      // extremes: far centre, reversed axis, widest radius, flat cylinder
      set_cylinder(32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0,
                   32'h0, 32'h7FFF_FFFF, 32'h0);
      repeat (N_RANDOM) send_random();

      // slanted axis, zero radius then a thin tube
      set_cylinder(32'h8000_0000, 32'h0, 32'h0, 32'h0000_B505, 32'h0000_B505, 32'h0,
                   32'h0, 32'h7FFF_FFFF);
      repeat (N_RANDOM / 4) send_random();
      set_cylinder(32'hFFFF_8000, 32'h0000_4000, 32'h0, 32'h0000_B505, 32'h0,
                   32'hFFFF_4AFB, 32'h0000_8000, 32'h0004_0000);
      repeat (N_RANDOM * 3 / 4) send_random();

      req_valid <= 1'b0;
      while (depth_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (n_bad == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
